// ===== hw/rtl/tick_tagged_replay_buffer_defines.svh =====
// Assertion macros shared by the replay buffer checker.
`ifndef TICK_TAGGED_REPLAY_BUFFER_DEFINES_SVH
`define TICK_TAGGED_REPLAY_BUFFER_DEFINES_SVH

// Same-cycle implication, off while rst_n is low.
`define TTRB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, off while rst_n is low.
`define TTRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== hw/rtl/ttrb_pkg.sv =====
// Package: sizes, codes, command word and engine states of the replay buffer.
`default_nettype none

package ttrb_pkg;

  localparam int DEPTH        = 32;
  localparam int PAYLOAD_BITS = 64;
  localparam int SLOT_W       = $clog2(DEPTH);
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int TICK_W       = 32;
  localparam int ACTION_W     = 3;
  localparam int OCC_W        = 6;
  localparam int PAY_PORT_W   = 64;

  // input word: action, tick_arg, payload_in
  localparam int IN_TICK_LSB  = ACTION_W;
  localparam int IN_PAY_LSB   = ACTION_W + TICK_W;
  localparam int IN_TDATA_W   = ((IN_PAY_LSB + PAY_PORT_W + 7) / 8) * 8;

  // result word: tick_out, payload_out, occupancy
  localparam int OUT_USED_W   = TICK_W + PAY_PORT_W + OCC_W;
  localparam int OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_USED_W;

  localparam int QUEUE_DEPTH  = 2;

  localparam logic [ACTION_W-1:0] ACT_PUSH       = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_ACK        = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP     = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_READ_AFTER = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_LATEST     = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd5;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_ACK,
    OP_LOOKUP,
    OP_READ_AFTER,
    OP_LATEST,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic [TICK_W-1:0]       tick_arg;
    logic [PAYLOAD_BITS-1:0] payload;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACK,
    ST_LOOKUP,
    ST_LK_READ,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ttrb_front.sv =====
// Front end: takes input words, decodes the action and queues commands.
`default_nettype none

module ttrb_front (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [ttrb_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                                    cmd_valid,
  input  wire logic                               cmd_ready,
  output ttrb_pkg::cmd_t                          cmd
);

  localparam int QP_W = (ttrb_pkg::QUEUE_DEPTH > 1) ? $clog2(ttrb_pkg::QUEUE_DEPTH) : 1;
  localparam int QF_W = $clog2(ttrb_pkg::QUEUE_DEPTH + 1);

  ttrb_pkg::cmd_t  q_r [ttrb_pkg::QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QP_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QF_W-1:0] fill_r, fill_nxt;
  logic            push, pop;
  ttrb_pkg::cmd_t  dec;

  function automatic ttrb_pkg::op_t decode(input logic [ttrb_pkg::ACTION_W-1:0] act);
    ttrb_pkg::op_t op;
    unique case (act)
      ttrb_pkg::ACT_PUSH:       op = ttrb_pkg::OP_PUSH;
      ttrb_pkg::ACT_ACK:        op = ttrb_pkg::OP_ACK;
      ttrb_pkg::ACT_LOOKUP:     op = ttrb_pkg::OP_LOOKUP;
      ttrb_pkg::ACT_READ_AFTER: op = ttrb_pkg::OP_READ_AFTER;
      ttrb_pkg::ACT_LATEST:     op = ttrb_pkg::OP_LATEST;
      ttrb_pkg::ACT_CLEAR:      op = ttrb_pkg::OP_CLEAR;
      default:                  op = ttrb_pkg::OP_NOP;
    endcase
    return op;
  endfunction

  function automatic logic [QP_W-1:0] ptr_inc(input logic [QP_W-1:0] p);
    return (p == QP_W'(ttrb_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign in_tready = (fill_r != QF_W'(ttrb_pkg::QUEUE_DEPTH));
  assign cmd_valid = (fill_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    dec.op       = decode(in_tdata[ttrb_pkg::ACTION_W-1:0]);
    dec.tick_arg = in_tdata[ttrb_pkg::IN_TICK_LSB +: ttrb_pkg::TICK_W];
    dec.payload  = in_tdata[ttrb_pkg::IN_PAY_LSB +: ttrb_pkg::PAYLOAD_BITS];
  end

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ttrb_engine.sv =====
// Back end: entry memory, ring pointers, tick counter, command sequencer and result register.
`default_nettype none

module ttrb_engine (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cmd_valid,
  output logic                                     cmd_ready,
  input  wire ttrb_pkg::cmd_t                      cmd,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [ttrb_pkg::OUT_TDATA_W-1:0]         out_tdata,
  output logic                                     out_tuser,
  output logic                                     out_tlast
);

  localparam int SLOT_W = ttrb_pkg::SLOT_W;
  localparam int CNT_W  = ttrb_pkg::CNT_W;
  localparam int TICK_W = ttrb_pkg::TICK_W;
  localparam int PAY_W  = ttrb_pkg::PAYLOAD_BITS;
  localparam int SUM_W  = CNT_W + 1;

  logic [PAY_W-1:0] entry_mem [ttrb_pkg::DEPTH];
  logic [PAY_W-1:0] rd_data_r;

  ttrb_pkg::state_t  state_r, state_nxt;
  logic [SLOT_W-1:0] oldest_r, oldest_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TICK_W-1:0] tc_r, tc_nxt;
  logic [TICK_W-1:0] head_r, head_nxt;     // tick of the oldest entry, tc - cnt + 1
  logic [TICK_W-1:0] arg_r, arg_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;     // scan tick, then result tick
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [CNT_W-1:0]  off_r, off_nxt;
  logic              last_r, last_nxt;
  logic              tail_le_r, tail_le_nxt;
  logic              res_found_r, res_found_nxt;
  logic [PAY_W-1:0]  res_pay_r, res_pay_nxt;
  logic              mem_pay_r, mem_pay_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    out_found_r, out_found_nxt;
  logic [TICK_W-1:0]       out_tick_r, out_tick_nxt;
  logic [PAY_W-1:0]        out_pay_r, out_pay_nxt;
  logic [ttrb_pkg::OCC_W-1:0] out_occ_r, out_occ_nxt;
  logic                    out_last_r, out_last_nxt;

  logic              wr_en, rd_en;
  logic [SLOT_W-1:0] wr_slot, rd_addr;
  logic              out_free, pop_ok, lk_hit, scan_end, scan_hit;
  logic [TICK_W-1:0] lk_off;

  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                  input logic [CNT_W-1:0]  ofs);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(ofs);
    if (sum >= SUM_W'(ttrb_pkg::DEPTH)) begin
      sum = sum - SUM_W'(ttrb_pkg::DEPTH);
    end
    return sum[SLOT_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(ttrb_pkg::DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  assign cmd_ready = (state_r == ttrb_pkg::ST_IDLE);
  assign out_free  = !out_valid_r || out_tready;
  assign pop_ok    = (cnt_r != '0) && (head_r <= arg_r);
  assign lk_off    = arg_r - head_r;
  assign lk_hit    = (cnt_r != '0) && (lk_off < TICK_W'(cnt_r));
  assign scan_end  = (idx_r == cnt_r);
  assign scan_hit  = !scan_end && (tick_r > arg_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ttrb_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op)
            ttrb_pkg::OP_ACK:        state_nxt = ttrb_pkg::ST_ACK;
            ttrb_pkg::OP_LOOKUP:     state_nxt = ttrb_pkg::ST_LOOKUP;
            ttrb_pkg::OP_READ_AFTER: state_nxt = ttrb_pkg::ST_SCAN;
            default:                 state_nxt = ttrb_pkg::ST_EMIT;
          endcase
        end
      end
      ttrb_pkg::ST_ACK: begin
        if (!pop_ok) state_nxt = ttrb_pkg::ST_EMIT;
      end
      ttrb_pkg::ST_LOOKUP: begin
        state_nxt = lk_hit ? ttrb_pkg::ST_LK_READ : ttrb_pkg::ST_EMIT;
      end
      ttrb_pkg::ST_LK_READ: begin
        state_nxt = ttrb_pkg::ST_EMIT;
      end
      ttrb_pkg::ST_SCAN: begin
        if (scan_end || scan_hit) state_nxt = ttrb_pkg::ST_EMIT;
      end
      ttrb_pkg::ST_EMIT: begin
        if (out_free) state_nxt = last_r ? ttrb_pkg::ST_IDLE : ttrb_pkg::ST_SCAN;
      end
      default: state_nxt = ttrb_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    oldest_nxt    = oldest_r;
    cnt_nxt       = cnt_r;
    tc_nxt        = tc_r;
    head_nxt      = head_r;
    arg_nxt       = arg_r;
    idx_nxt       = idx_r;
    tick_nxt      = tick_r;
    slot_nxt      = slot_r;
    off_nxt       = off_r;
    last_nxt      = last_r;
    tail_le_nxt   = tail_le_r;
    res_found_nxt = res_found_r;
    res_pay_nxt   = res_pay_r;
    mem_pay_nxt   = mem_pay_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    wr_slot       = '0;
    rd_addr       = '0;

    out_valid_nxt = out_valid_r && !out_tready;
    out_found_nxt = out_found_r;
    out_tick_nxt  = out_tick_r;
    out_pay_nxt   = out_pay_r;
    out_occ_nxt   = out_occ_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ttrb_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          // empty result unless the command overrides it
          res_found_nxt = 1'b0;
          tick_nxt      = '0;
          res_pay_nxt   = '0;
          mem_pay_nxt   = 1'b0;
          last_nxt      = 1'b1;
          arg_nxt       = cmd.tick_arg;
          unique case (cmd.op)
            ttrb_pkg::OP_PUSH: begin
              tc_nxt = tc_r + 1'b1;
              wr_en  = 1'b1;
              if (cnt_r == CNT_W'(ttrb_pkg::DEPTH)) begin
                wr_slot    = oldest_r;
                oldest_nxt = slot_inc(oldest_r);
                head_nxt   = head_r + 1'b1;
              end else begin
                wr_slot = slot_add(oldest_r, cnt_r);
                cnt_nxt = cnt_r + 1'b1;
              end
              res_found_nxt = 1'b1;
              tick_nxt      = tc_r + 1'b1;
              res_pay_nxt   = cmd.payload;
            end
            ttrb_pkg::OP_READ_AFTER: begin
              idx_nxt     = '0;
              tick_nxt    = head_r;
              slot_nxt    = oldest_r;
              tail_le_nxt = (tc_r <= cmd.tick_arg);
            end
            ttrb_pkg::OP_LATEST: begin
              if (cnt_r != '0) begin
                rd_en         = 1'b1;
                rd_addr       = slot_add(oldest_r, cnt_r - 1'b1);
                res_found_nxt = 1'b1;
                tick_nxt      = tc_r;
                mem_pay_nxt   = 1'b1;
              end
            end
            ttrb_pkg::OP_CLEAR: begin
              cnt_nxt    = '0;
              oldest_nxt = '0;
              head_nxt   = tc_r + 1'b1;
            end
            default: ;
          endcase
        end
      end
      ttrb_pkg::ST_ACK: begin
        if (pop_ok) begin
          oldest_nxt = slot_inc(oldest_r);
          cnt_nxt    = cnt_r - 1'b1;
          head_nxt   = head_r + 1'b1;
        end
      end
      ttrb_pkg::ST_LOOKUP: begin
        if (lk_hit) begin
          off_nxt       = lk_off[CNT_W-1:0];
          res_found_nxt = 1'b1;
          tick_nxt      = arg_r;
          mem_pay_nxt   = 1'b1;
        end
      end
      ttrb_pkg::ST_LK_READ: begin
        rd_en   = 1'b1;
        rd_addr = slot_add(oldest_r, off_r);
      end
      ttrb_pkg::ST_SCAN: begin
        if (scan_end) begin
          res_found_nxt = 1'b0;
          tick_nxt      = '0;
          res_pay_nxt   = '0;
          mem_pay_nxt   = 1'b0;
          last_nxt      = 1'b1;
        end else if (scan_hit) begin
          rd_en         = 1'b1;
          rd_addr       = slot_r;
          res_found_nxt = 1'b1;
          mem_pay_nxt   = 1'b1;
          // ticks rise by one until the wrap; past it nothing beats arg unless the tail does
          last_nxt      = ((idx_r + 1'b1) == cnt_r) || ((tick_r == '1) && tail_le_r);
        end else begin
          idx_nxt  = idx_r + 1'b1;
          tick_nxt = tick_r + 1'b1;
          slot_nxt = slot_inc(slot_r);
        end
      end
      ttrb_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_tick_nxt  = tick_r;
          out_pay_nxt   = mem_pay_r ? rd_data_r : res_pay_r;
          out_occ_nxt   = ttrb_pkg::OCC_W'(cnt_r);
          out_last_nxt  = last_r;
          if (!last_r) begin
            idx_nxt  = idx_r + 1'b1;
            tick_nxt = tick_r + 1'b1;
            slot_nxt = slot_inc(slot_r);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ttrb_pkg::ST_IDLE;
      oldest_r    <= '0;
      cnt_r       <= '0;
      tc_r        <= '0;
      head_r      <= TICK_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      cnt_r       <= cnt_nxt;
      tc_r        <= tc_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    arg_r       <= arg_nxt;
    idx_r       <= idx_nxt;
    tick_r      <= tick_nxt;
    slot_r      <= slot_nxt;
    off_r       <= off_nxt;
    last_r      <= last_nxt;
    tail_le_r   <= tail_le_nxt;
    res_found_r <= res_found_nxt;
    res_pay_r   <= res_pay_nxt;
    mem_pay_r   <= mem_pay_nxt;
    out_found_r <= out_found_nxt;
    out_tick_r  <= out_tick_nxt;
    out_pay_r   <= out_pay_nxt;
    out_occ_r   <= out_occ_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_slot] <= cmd.payload;
    end
    if (rd_en) begin
      rd_data_r <= entry_mem[rd_addr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{ttrb_pkg::OUT_PAD_W{1'b0}}, out_occ_r,
                       ttrb_pkg::PAY_PORT_W'(out_pay_r), out_tick_r};

endmodule

`default_nettype wire

// ===== hw/rtl/tick_tagged_replay_buffer.sv =====
// Top level of the tick-tagged replay buffer: command front end and execution engine.
//
//  channel | ports          | word
//  --------+----------------+----------------------------------------------------------
//  in      | in_t*          | tdata: action[2:0], tick_arg[34:3], payload_in[98:35]
//  out     | out_t*         | tdata: tick_out[31:0], payload_out[95:32], occupancy[101:96]
//          |                | tuser: found, tlast: last
//
// Each input word passes a 2-deep command queue; the engine then goes straight to the emit state
// for push, latest, clear and unknown actions, pops entries in its acknowledge state for
// acknowledge, adds a memory read on a lookup hit, and for read-after scans the entries held,
// emitting each result as it is found.
// rst_n empties the buffer and zeroes the tick counter; memory contents are not cleared.
// A stalled out channel parks one result in the output register while the queue keeps filling.
`default_nettype none

module tick_tagged_replay_buffer (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [ttrb_pkg::IN_TDATA_W-1:0]     in_tdata,   // action, tick_arg, payload_in
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [ttrb_pkg::OUT_TDATA_W-1:0]         out_tdata,  // tick_out, payload_out, occupancy
  output logic                                     out_tuser,  // found
  output logic                                     out_tlast
);

  logic           cmd_valid;
  logic           cmd_ready;
  ttrb_pkg::cmd_t cmd;

  ttrb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  ttrb_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/ttrb_checker.sv =====
// Port-level checks on the replay buffer result channel, bound to the top level.
`default_nettype none
`include "tick_tagged_replay_buffer_defines.svh"

module ttrb_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [ttrb_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input wire logic                              out_tuser,
  input wire logic                              out_tlast
);

  localparam int ZERO_W = ttrb_pkg::TICK_W + ttrb_pkg::PAY_PORT_W;

  // a miss carries neither tick nor payload
  `TTRB_ASSERT_NOW(a_miss_zero, clk, rst_n, out_tvalid && !out_tuser, out_tdata[ZERO_W-1:0] == '0)

  // only read-after gives more than one word per input, and those all carry entries
  `TTRB_ASSERT_NOW(a_run_found, clk, rst_n, out_tvalid && !out_tlast, out_tuser)

  `TTRB_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

endmodule

bind tick_tagged_replay_buffer ttrb_checker u_ttrb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

// ===== tb/tick_tagged_replay_buffer_checker.sv =====
// Checker for the replay buffer: watches both channels, predicts each result word and compares.
`timescale 1ns / 100ps

module tick_tagged_replay_buffer_checker
  import ttrb_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  input  wire logic                   in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // action, tick_arg, payload_in
  input  wire logic                   out_tvalid,
  input  wire logic                   out_tready,
  input  wire logic [OUT_TDATA_W-1:0] out_tdata,  // tick_out, payload_out, occupancy
  input  wire logic                   out_tuser,  // found
  input  wire logic                   out_tlast,
  output int                          fail_count,
  output int                          pending,
  output int                          results_seen
);

  localparam bit [PAY_PORT_W-1:0] PAY_KEEP = {PAY_PORT_W{1'b1}} >> (PAY_PORT_W - PAYLOAD_BITS);

  typedef struct {
    bit                  found;
    bit [TICK_W-1:0]     tick;
    bit [PAY_PORT_W-1:0] payload;
    bit [OCC_W-1:0]      occ;
    bit                  last;
  } reply_t;

  reply_t              replies_due[$];
  bit [PAY_PORT_W-1:0] slot_word[DEPTH];
  int unsigned         head_slot;
  int unsigned         held;
  bit [TICK_W-1:0]     newest_tick;

  // entries hold consecutive ticks ending at newest_tick
  function automatic bit [TICK_W-1:0] tick_at(int unsigned i);
    return newest_tick - TICK_W'(held) + TICK_W'(1) + TICK_W'(i);
  endfunction

  function automatic bit [PAY_PORT_W-1:0] word_at(int unsigned i);
    return slot_word[(head_slot + i) % DEPTH];
  endfunction

  function automatic void queue_reply(bit found, bit [TICK_W-1:0] tick,
                                      bit [PAY_PORT_W-1:0] payload, bit last);
    reply_t r;
    r.found   = found;
    r.tick    = tick;
    r.payload = payload & PAY_KEEP;
    r.occ     = OCC_W'(held);
    r.last    = last;
    replies_due.insert(replies_due.size(), r);
  endfunction

  function automatic void apply_command(bit [ACTION_W-1:0] act, bit [TICK_W-1:0] arg,
                                        bit [PAY_PORT_W-1:0] pay);
    bit [TICK_W-1:0] off;
    int unsigned     hits;
    int unsigned     k;
    pay = pay & PAY_KEEP;
    case (act)
      ACT_PUSH: begin
        newest_tick++;
        if (held >= DEPTH) begin
          // full: overwrite the oldest slot
          slot_word[head_slot] = pay;
          head_slot = (head_slot + 1) % DEPTH;
        end else begin
          slot_word[(head_slot + held) % DEPTH] = pay;
          held++;
        end
        queue_reply(1'b1, newest_tick, pay, 1'b1);
        return;
      end
      ACT_ACK: begin
        while (held > 0 && tick_at(0) <= arg) begin
          head_slot = (head_slot + 1) % DEPTH;
          held--;
        end
      end
      ACT_LOOKUP: begin
        off = arg - tick_at(0);
        if (held > 0 && off < TICK_W'(held)) begin
          queue_reply(1'b1, arg, word_at(int'(off)), 1'b1);
          return;
        end
      end
      ACT_READ_AFTER: begin
        hits = 0;
        for (int unsigned i = 0; i < held; i++)
          if (tick_at(i) > arg) hits++;
        if (hits > 0) begin
          k = 0;
          for (int unsigned i = 0; i < held; i++) begin
            if (tick_at(i) > arg) begin
              k++;
              queue_reply(1'b1, tick_at(i), word_at(i), k == hits);
            end
          end
          return;
        end
      end
      ACT_LATEST: begin
        if (held > 0) begin
          queue_reply(1'b1, newest_tick, word_at(held - 1), 1'b1);
          return;
        end
      end
      ACT_CLEAR: begin
        held      = 0;
        head_slot = 0;
      end
      default: ;
    endcase
    queue_reply(1'b0, '0, '0, 1'b1);
  endfunction

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin
    reply_t             want;
    bit [TICK_W-1:0]     got_tick;
    bit [PAY_PORT_W-1:0] got_pay;
    bit [OCC_W-1:0]      got_occ;
    if (!rst_n) begin
      replies_due.delete();
      head_slot   = 0;
      held        = 0;
      newest_tick = '0;
    end else begin
      if (in_tvalid && in_tready)
        apply_command(in_tdata[ACTION_W-1:0], in_tdata[IN_TICK_LSB +: TICK_W],
                      in_tdata[IN_PAY_LSB +: PAY_PORT_W]);
      if (out_tvalid && out_tready) begin
        results_seen++;
        got_tick = out_tdata[TICK_W-1:0];
        got_pay  = out_tdata[TICK_W +: PAY_PORT_W];
        got_occ  = out_tdata[TICK_W + PAY_PORT_W +: OCC_W];
        if (replies_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result word: found=%0b tick=%0h payload=%h occ=%0d last=%0b",
                     out_tuser, got_tick, got_pay, got_occ, out_tlast);
        end else begin
          want = replies_due[0];
          replies_due.delete(0);
          if (out_tuser !== want.found || got_tick !== want.tick || got_pay !== want.payload
              || got_occ !== want.occ || out_tlast !== want.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"mismatch: expected found=%0b tick=%0h payload=%h occ=%0d last=%0b,",
                        " got found=%0b tick=%0h payload=%h occ=%0d last=%0b"},
                       want.found, want.tick, want.payload, want.occ, want.last,
                       out_tuser, got_tick, got_pay, got_occ, out_tlast);
          end
        end
      end
    end
    pending = replies_due.size();
  end

endmodule

// ===== tb/tick_tagged_replay_buffer_test.sv =====
// Testbench top for the replay buffer: clock, reset, command stimulus, result pacing and verdict.
`timescale 1ns / 100ps

module tick_tagged_replay_buffer_test;
  import ttrb_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_RSVD_LO = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_RSVD_HI = 3'd7;
  localparam int HOLD_CYCLES  = 90;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_WORDS = 40;
  localparam int FILL_PUSHES  = 40;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // action, tick_arg, payload_in
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // tick_out, payload_out, occupancy
  logic                   out_tuser;       // found
  logic                   out_tlast;

  int fail_count;
  int pending;
  int results_seen;

  bit              calm = 1'b0;      // no idling on either side
  bit              hold_req = 1'b0;  // asks the sink for one long hold-off
  bit [TICK_W-1:0] ticks_issued = '0;
  int              words_sent = 0;

  tick_tagged_replay_buffer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  tick_tagged_replay_buffer_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .fail_count  (fail_count),
    .pending     (pending),
    .results_seen(results_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // offer one word, return once it is taken
  task automatic send_word(input logic [ACTION_W-1:0] act, input logic [TICK_W-1:0] arg,
                           input logic [PAY_PORT_W-1:0] pay);
    logic [IN_TDATA_W-1:0] w;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    w = '0;
    w[ACTION_W-1:0]             = act;
    w[IN_TICK_LSB +: TICK_W]    = arg;
    w[IN_PAY_LSB +: PAY_PORT_W] = pay;
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    do @(posedge clk); while (!in_tready);
    words_sent++;
    if (act == ACT_PUSH) ticks_issued++;
  endtask

  // one edge first so the checker has counted the last word taken
  task automatic pause_until_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [PAY_PORT_W-1:0] rand_payload();
    return {$urandom, $urandom};
  endfunction

  // mostly near the live window, sometimes anywhere in the 32-bit range
  function automatic logic [TICK_W-1:0] pick_tick(int span);
    if ($urandom_range(0, 5) == 0) return $urandom;
    return ticks_issued - TICK_W'($urandom_range(0, span));
  endfunction

  // result side pacing
  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ends the run if neither channel moves for too long
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending);
        $display("tick_tagged_replay_buffer_test: errors");
        $finish;
      end
    end
  end

  initial begin
    int r;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty buffer
    send_word(ACT_LATEST, '0, '0);
    send_word(ACT_READ_AFTER, '0, '0);
    send_word(ACT_LOOKUP, '0, rand_payload());
    send_word(ACT_ACK, '1, '0);
    // payload extremes, ticks 1..4
    send_word(ACT_PUSH, '1, '0);
    send_word(ACT_PUSH, '0, '1);
    send_word(ACT_PUSH, $urandom, 64'hA5A5_A5A5_A5A5_A5A5);
    send_word(ACT_PUSH, $urandom, 64'h5A5A_5A5A_5A5A_5A5A);
    send_word(ACT_LOOKUP, 32'd1, '0);
    send_word(ACT_LOOKUP, 32'd4, '0);
    send_word(ACT_LOOKUP, 32'd5, '0);
    send_word(ACT_LOOKUP, 32'd0, '0);
    send_word(ACT_READ_AFTER, 32'd0, '0);
    send_word(ACT_READ_AFTER, 32'd2, '0);
    send_word(ACT_READ_AFTER, 32'd4, '0);
    send_word(ACT_READ_AFTER, '1, '0);
    send_word(ACT_LATEST, $urandom, rand_payload());
    send_word(ACT_ACK, 32'd2, '0);
    send_word(ACT_RSVD_LO, $urandom, rand_payload());
    send_word(ACT_RSVD_HI, $urandom, rand_payload());
    send_word(ACT_LOOKUP, 32'd1, '0);
    // clear keeps the tick counter
    send_word(ACT_CLEAR, $urandom, rand_payload());
    send_word(ACT_LATEST, '0, '0);
    send_word(ACT_PUSH, $urandom, rand_payload());
    send_word(ACT_LOOKUP, 32'd5, '0);

    pause_until_drained();

    // overfill while the sink holds off, so the input backs up
    hold_req = 1'b1;
    for (int i = 0; i < FILL_PUSHES; i++)
      send_word(ACT_PUSH, $urandom, rand_payload());
    send_word(ACT_READ_AFTER, ticks_issued - TICK_W'(FILL_PUSHES), '0);
    send_word(ACT_LOOKUP, ticks_issued - TICK_W'(DEPTH + 3), '0);
    send_word(ACT_LOOKUP, ticks_issued - TICK_W'(DEPTH - 1), '0);
    send_word(ACT_ACK, ticks_issued - TICK_W'(DEPTH - 4), '0);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS - 25) calm = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 40)      send_word(ACT_PUSH, $urandom, rand_payload());
      else if (r < 50) send_word(ACT_ACK, pick_tick(20), rand_payload());
      else if (r < 64) send_word(ACT_LOOKUP, pick_tick(36), rand_payload());
      else if (r < 76) send_word(ACT_READ_AFTER, pick_tick(34), rand_payload());
      else if (r < 84) send_word(ACT_LATEST, $urandom, rand_payload());
      else if (r < 89) send_word(ACT_CLEAR, $urandom, rand_payload());
      else if (r < 95) send_word(r[0] ? ACT_RSVD_HI : ACT_RSVD_LO, $urandom, rand_payload());
      else begin
        // short push run then a read-back of it
        repeat ($urandom_range(2, 8)) send_word(ACT_PUSH, $urandom, rand_payload());
        send_word(ACT_READ_AFTER, pick_tick(10), rand_payload());
      end
    end

    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d command words (%0d pushes, overfill past depth %0d), checked %0d results",
             words_sent, ticks_issued, DEPTH, results_seen);
    $display("%0d failures recorded", fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tick_tagged_replay_buffer_test: clean");
    end else begin
      $display("tick_tagged_replay_buffer_test: errors");
    end
    $finish;
  end

endmodule
